>>> rtl/lis_pkg.sv
// Package for the light and irrigation scheduler.
// Holds the item structs, status, alert and register index codes, and constants.
// No dependencies.
`timescale 1ns / 1ps

package lis_pkg;

    // Field widths
    localparam int unsigned NOW_W     = 32;
    localparam int unsigned HOUR_W    = 5;
    localparam int unsigned MINUTE_W  = 6;
    localparam int unsigned PH_W      = 11;
    localparam int unsigned MINS_W    = 11;
    localparam int unsigned SECS_W    = 22;
    localparam int unsigned WMIN_W    = 16;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DAT_W = 16;

    // Scheduling constants
    localparam logic [NOW_W-1:0]  SYNC_THRESHOLD = 32'd1000000000;
    localparam logic [5:0]        HOURS_PER_DAY  = 6'd24;
    localparam logic [5:0]        TWO_DAYS_HOURS = 6'd48;
    localparam logic [MINS_W-1:0] MINUTES_PER_DAY = 11'd1440;

    // Register reset values
    localparam logic [HOUR_W-1:0] LIGHT_START_RESET  = 5'd6;
    localparam logic [HOUR_W-1:0] LIGHT_LENGTH_RESET = 5'd12;
    localparam logic [SECS_W-1:0] INTERVAL_SEC_RESET = 22'd3600;  // 60 minutes
    localparam logic [SECS_W-1:0] DURATION_SEC_RESET = 22'd300;   // 5 minutes
    localparam logic [PH_W-1:0]   PH_LOW_RESET       = 11'd550;
    localparam logic [PH_W-1:0]   PH_HIGH_RESET      = 11'd650;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LIGHT_START    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LIGHT_LENGTH   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WATER_INTERVAL = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WATER_DURATION = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PH_LOW         = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_PH_HIGH        = 3'd5;

    // Step status codes
    localparam logic [1:0] STATUS_RAN      = 2'd0;
    localparam logic [1:0] STATUS_NO_CYCLE = 2'd1;
    localparam logic [1:0] STATUS_UNSYNCED = 2'd2;
    localparam logic [1:0] STATUS_NO_STAGE = 2'd3;

    // pH alert codes
    localparam logic [1:0] ALERT_NONE = 2'd0;
    localparam logic [1:0] ALERT_LOW  = 2'd1;
    localparam logic [1:0] ALERT_HIGH = 2'd2;

    typedef struct packed {
        logic [NOW_W-1:0]    now_seconds;
        logic [HOUR_W-1:0]   local_hour;
        logic [MINUTE_W-1:0] local_minute;
        logic                cycle_active;
        logic                stage_available;
        logic                lights_now;
        logic                pump_now;
        logic [PH_W-1:0]     ph_sample;
        logic                ph_present;
    } tick_t;

    typedef struct packed {
        logic [1:0]        step_status;
        logic              lights_wanted;
        logic              lights_toggle;
        logic [MINS_W-1:0] minutes_to_light_change;
        logic              pump_command;
        logic              pump_started;
        logic              pump_stopped;
        logic [SECS_W-1:0] seconds_to_watering;
        logic [1:0]        ph_alert;
    } result_t;

    // Minutes to seconds: x*60 = x*64 - x*4, exact in SECS_W bits.
    function automatic logic [SECS_W-1:0] min_to_sec(input logic [WMIN_W-1:0] m);
        logic [SECS_W-1:0] x;
        x = {{(SECS_W-WMIN_W){1'b0}}, m};
        return (x << 6) - (x << 2);
    endfunction

endpackage

>>> rtl/light_and_irrigation_scheduler.sv
// Light and irrigation scheduler top level: input register, one-pass
// schedule logic, result register and scheduler state. Depends on lis_pkg.
`timescale 1ns / 1ps

//  Channel  | Signals                          | Direction | Moves
//  ---------+----------------------------------+-----------+----------------------
//  tick     | tick_valid, tick_ready, tick     | in        | one schedule tick item
//  result   | result_valid, result_ready, result | out     | one result item per tick
//  config   | wr_en, wr_index, wr_data         | in        | register write, no wait
//
//  Each item waits in the input register and is then registered as its
//  result; with result_ready high a new item is taken every cycle. The
//  scheduler state updates at the edge that registers the result, so the
//  next item sees it at once. A stalled result holds in the output register
//  while one more item waits in the input register.
//  Reset clears the handshake, restores register defaults and arms the first tick.

module light_and_irrigation_scheduler (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                tick_valid,
    output logic                                tick_ready,
    input  lis_pkg::tick_t                      tick,
    output logic                                result_valid,
    input  logic                                result_ready,
    output lis_pkg::result_t                    result,
    input  logic                                wr_en,
    input  logic [lis_pkg::CFG_IDX_W-1:0]       wr_index,
    input  logic [lis_pkg::CFG_DAT_W-1:0]       wr_data
);

    // ------------------------------------------------------------------
    // Configuration registers; watering times are kept in seconds so the
    // item path has no multiply.
    // ------------------------------------------------------------------
    logic [lis_pkg::HOUR_W-1:0] light_start_reg;
    logic [lis_pkg::HOUR_W-1:0] light_length_reg;
    logic [lis_pkg::SECS_W-1:0] interval_sec_reg;
    logic [lis_pkg::SECS_W-1:0] duration_sec_reg;
    logic [lis_pkg::PH_W-1:0]   ph_low_reg;
    logic [lis_pkg::PH_W-1:0]   ph_high_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            light_start_reg  <= lis_pkg::LIGHT_START_RESET;
            light_length_reg <= lis_pkg::LIGHT_LENGTH_RESET;
            interval_sec_reg <= lis_pkg::INTERVAL_SEC_RESET;
            duration_sec_reg <= lis_pkg::DURATION_SEC_RESET;
            ph_low_reg       <= lis_pkg::PH_LOW_RESET;
            ph_high_reg      <= lis_pkg::PH_HIGH_RESET;
        end
        else if (wr_en)
        begin
            case (wr_index)
                lis_pkg::CFG_LIGHT_START:    light_start_reg  <= wr_data[lis_pkg::HOUR_W-1:0];
                lis_pkg::CFG_LIGHT_LENGTH:   light_length_reg <= wr_data[lis_pkg::HOUR_W-1:0];
                lis_pkg::CFG_WATER_INTERVAL: interval_sec_reg <= lis_pkg::min_to_sec(wr_data);
                lis_pkg::CFG_WATER_DURATION: duration_sec_reg <= lis_pkg::min_to_sec(wr_data);
                lis_pkg::CFG_PH_LOW:         ph_low_reg       <= wr_data[lis_pkg::PH_W-1:0];
                lis_pkg::CFG_PH_HIGH:        ph_high_reg      <= wr_data[lis_pkg::PH_W-1:0];
                default:                     ;  // indexes past the list are dropped
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Handshake: advance moves the input register into the result register.
    // ------------------------------------------------------------------
    logic             tick_valid_reg;
    lis_pkg::tick_t   tick_reg;
    logic             result_valid_reg;
    lis_pkg::result_t result_reg;
    lis_pkg::result_t result_next;
    logic             advance;

    assign advance      = tick_valid_reg && (!result_valid_reg || result_ready);
    assign tick_ready   = !tick_valid_reg || advance;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // ------------------------------------------------------------------
    // Scheduler state
    // ------------------------------------------------------------------
    logic                      first_tick_reg;
    logic                      first_tick_next;
    logic [lis_pkg::NOW_W-1:0] last_water_reg;
    logic [lis_pkg::NOW_W-1:0] last_water_next;
    logic [lis_pkg::NOW_W-1:0] pump_start_reg;
    logic [lis_pkg::NOW_W-1:0] pump_start_next;

    // ------------------------------------------------------------------
    // Status: cycle, then time sync, then stage.
    // ------------------------------------------------------------------
    logic [1:0] status;

    always_comb
    begin
        if (!tick_reg.cycle_active)
            status = lis_pkg::STATUS_NO_CYCLE;
        else if (tick_reg.now_seconds < lis_pkg::SYNC_THRESHOLD)
            status = lis_pkg::STATUS_UNSYNCED;
        else if (!tick_reg.stage_available)
            status = lis_pkg::STATUS_NO_STAGE;
        else
            status = lis_pkg::STATUS_RAN;
    end

    // ------------------------------------------------------------------
    // Lights: window [start, end) with end = (start + length) mod 24.
    // Equal start and end means lights on all day.
    // ------------------------------------------------------------------
    logic [5:0]                 end_sum;
    logic [lis_pkg::HOUR_W-1:0] end_hour;
    logic                       want;
    logic [lis_pkg::HOUR_W-1:0] target;
    logic signed [6:0]          hour_diff;
    logic signed [12:0]         diff_ext;
    logic signed [12:0]         mins_raw;
    logic [lis_pkg::MINS_W-1:0] mins;

    always_comb
    begin
        end_sum = {1'b0, light_start_reg} + {1'b0, light_length_reg};
        if (end_sum >= lis_pkg::TWO_DAYS_HOURS)
            end_sum = end_sum - lis_pkg::TWO_DAYS_HOURS;
        else if (end_sum >= lis_pkg::HOURS_PER_DAY)
            end_sum = end_sum - lis_pkg::HOURS_PER_DAY;
        end_hour = end_sum[lis_pkg::HOUR_W-1:0];

        if (light_start_reg < end_hour)
            want = (tick_reg.local_hour >= light_start_reg) && (tick_reg.local_hour < end_hour);
        else
            want = (tick_reg.local_hour >= light_start_reg) || (tick_reg.local_hour < end_hour);

        target = want ? end_hour : light_start_reg;

        // Hours to the next transition, wrapping into tomorrow when it has passed.
        if (tick_reg.local_hour < target)
            hour_diff = $signed({2'b00, target}) - $signed({2'b00, tick_reg.local_hour});
        else
            hour_diff = $signed({2'b00, target}) + $signed({1'b0, lis_pkg::HOURS_PER_DAY})
                        - $signed({2'b00, tick_reg.local_hour});

        // Times 60 as shift and subtract, then drop the minutes already gone.
        diff_ext = 13'(hour_diff);
        mins_raw = (diff_ext <<< 6) - (diff_ext <<< 2)
                   - $signed({7'b0, tick_reg.local_minute});

        if (mins_raw < 0)
            mins = '0;
        else if (mins_raw > $signed({2'b00, lis_pkg::MINUTES_PER_DAY}))
            mins = lis_pkg::MINUTES_PER_DAY;
        else
            mins = mins_raw[lis_pkg::MINS_W-1:0];
    end

    // ------------------------------------------------------------------
    // Watering. Elapsed times are signed so a clock running backwards never
    // starts or stops the pump.
    // ------------------------------------------------------------------
    logic signed [lis_pkg::NOW_W:0] since_water;
    logic signed [lis_pkg::NOW_W:0] since_pump;
    logic                           interval_due;
    logic                           duration_due;
    logic [lis_pkg::SECS_W-1:0]     wait_sec;
    logic                           pump;
    logic                           started;
    logic                           stopped;

    always_comb
    begin
        since_water  = $signed({1'b0, tick_reg.now_seconds}) - $signed({1'b0, last_water_reg});
        since_pump   = $signed({1'b0, tick_reg.now_seconds}) - $signed({1'b0, pump_start_reg});
        interval_due = !since_water[lis_pkg::NOW_W]
                       && (since_water[lis_pkg::NOW_W-1:0]
                           >= {{(lis_pkg::NOW_W-lis_pkg::SECS_W){1'b0}}, interval_sec_reg});
        duration_due = !since_pump[lis_pkg::NOW_W]
                       && (since_pump[lis_pkg::NOW_W-1:0]
                           >= {{(lis_pkg::NOW_W-lis_pkg::SECS_W){1'b0}}, duration_sec_reg});

        // Countdown from the state on entry; zero when never watered.
        if (last_water_reg == '0)
            wait_sec = '0;
        else if (since_water[lis_pkg::NOW_W])
            wait_sec = interval_sec_reg;
        else if (interval_due)
            wait_sec = '0;
        else
            wait_sec = interval_sec_reg - since_water[lis_pkg::SECS_W-1:0];

        first_tick_next = first_tick_reg;
        last_water_next = last_water_reg;
        pump_start_next = pump_start_reg;
        pump            = tick_reg.pump_now;
        started         = 1'b0;
        stopped         = 1'b0;

        if (first_tick_reg)
        begin
            pump            = 1'b1;
            last_water_next = tick_reg.now_seconds;
            first_tick_next = 1'b0;
            started         = 1'b1;
        end
        else if ((last_water_reg != '0) && interval_due)
        begin
            pump            = 1'b1;
            last_water_next = tick_reg.now_seconds;
            started         = 1'b1;
        end

        if (pump)
        begin
            if (pump_start_reg == '0)
                pump_start_next = tick_reg.now_seconds;
            else if (duration_due)
            begin
                pump            = 1'b0;
                pump_start_next = '0;
                stopped         = 1'b1;
            end
        end
        else
            pump_start_next = '0;

        // A refused tick leaves the state alone.
        if (status != lis_pkg::STATUS_RAN)
        begin
            first_tick_next = first_tick_reg;
            last_water_next = last_water_reg;
            pump_start_next = pump_start_reg;
        end
    end

    // ------------------------------------------------------------------
    // Result assembly
    // ------------------------------------------------------------------
    always_comb
    begin
        result_next = '0;
        result_next.step_status = status;
        if (status != lis_pkg::STATUS_RAN)
        begin
            result_next.lights_wanted = tick_reg.lights_now;
            result_next.pump_command  = tick_reg.pump_now;
        end
        else
        begin
            result_next.lights_wanted           = want;
            result_next.lights_toggle           = want ^ tick_reg.lights_now;
            result_next.minutes_to_light_change = mins;
            result_next.pump_command            = pump;
            result_next.pump_started            = started;
            result_next.pump_stopped            = stopped;
            result_next.seconds_to_watering     = wait_sec;
            // Too low is checked first, so a sample under the low limit and over the high limit reports low.
            if (!tick_reg.ph_present)
                result_next.ph_alert = lis_pkg::ALERT_NONE;
            else if (tick_reg.ph_sample < ph_low_reg)
                result_next.ph_alert = lis_pkg::ALERT_LOW;
            else if (tick_reg.ph_sample > ph_high_reg)
                result_next.ph_alert = lis_pkg::ALERT_HIGH;
            else
                result_next.ph_alert = lis_pkg::ALERT_NONE;
        end
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
            first_tick_reg   <= 1'b1;
            last_water_reg   <= '0;
            pump_start_reg   <= '0;
        end
        else
        begin
            if (tick_ready)
                tick_valid_reg <= tick_valid;
            if (advance)
            begin
                result_valid_reg <= 1'b1;
                first_tick_reg   <= first_tick_next;
                last_water_reg   <= last_water_next;
                pump_start_reg   <= pump_start_next;
            end
            else if (result_ready)
                result_valid_reg <= 1'b0;
        end
    end

    // Payload registers, no reset: hold while stalled.
    always_ff @(posedge clk)
    begin
        if (tick_valid && tick_ready)
            tick_reg <= tick;
        if (advance)
            result_reg <= result_next;
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // Expiry always leaves the pump off.
    a_stop_means_off: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.pump_stopped |-> !result.pump_command)
        else $error("pump stopped but still commanded on");

    // A refused tick never touches the pump schedule.
    a_refused_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.step_status != lis_pkg::STATUS_RAN)
        |-> !result.pump_started && !result.pump_stopped)
        else $error("refused tick changed the pump");

    // Clearing the first-tick flag goes with a watering start.
    a_first_start: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(first_tick_reg) |-> result_valid && result.pump_started)
        else $error("first tick consumed without a start");

    // Expiry clears the pump timer.
    a_stop_clears_timer: assert property (@(posedge clk) disable iff (!rst_n)
        advance && result_next.pump_stopped |=> pump_start_reg == '0)
        else $error("pump timer not cleared on expiry");

endmodule

>>> sim/light_and_irrigation_scheduler_tb.sv
// Self-checking testbench for the light and irrigation scheduler.
// Drives schedule ticks and register writes and checks every result item
// against an in-bench prediction of the schedule. Depends on lis_pkg.
`timescale 1ns / 1ps

module light_and_irrigation_scheduler_tb;

    // Run limits and pacing
    localparam int     CLK_HALF     = 5;
    localparam longint CYCLE_LIMIT  = 200000;
    localparam int     LONG_HOLD    = 400;   // cycles the receiver holds off once
    localparam int     PHASE_ITEMS  = 78;    // random items per register setting
    localparam int     RANDOM_SETS  = 9;
    localparam int     DRAIN_CYCLES = 6;     // extra wait for the pipeline to empty

    // Index values with no register behind them; writes there must be ignored
    localparam logic [lis_pkg::CFG_IDX_W-1:0] CFG_SPARE_6 = 3'd6;
    localparam logic [lis_pkg::CFG_IDX_W-1:0] CFG_SPARE_7 = 3'd7;

    localparam longint SYNC_SECONDS = 64'd1000000000;

    // ------------------------------------------------------------------
    // Schedule ledger: own copy of the registers and scheduler state,
    // predicts each accepted tick and holds the outcomes still to arrive.
    // ------------------------------------------------------------------
    class tick_ledger;
        logic [lis_pkg::HOUR_W-1:0] light_start;
        logic [lis_pkg::HOUR_W-1:0] light_length;
        logic [lis_pkg::WMIN_W-1:0] interval_min;
        logic [lis_pkg::WMIN_W-1:0] duration_min;
        logic [lis_pkg::PH_W-1:0]   ph_low;
        logic [lis_pkg::PH_W-1:0]   ph_high;
        bit                         first_pending;
        logic [lis_pkg::NOW_W-1:0]  last_start;
        logic [lis_pkg::NOW_W-1:0]  pump_since;
        lis_pkg::result_t           outcomes[$];
        int                         errors;
        int                         checked;
        int                         refused;
        int                         starts;
        int                         stops;

        function new();
            light_start   = lis_pkg::LIGHT_START_RESET;
            light_length  = lis_pkg::LIGHT_LENGTH_RESET;
            interval_min  = 16'd60;
            duration_min  = 16'd5;
            ph_low        = lis_pkg::PH_LOW_RESET;
            ph_high       = lis_pkg::PH_HIGH_RESET;
            first_pending = 1'b1;
            last_start    = '0;
            pump_since    = '0;
            errors        = 0;
            checked       = 0;
            refused       = 0;
            starts        = 0;
            stops         = 0;
        endfunction

        function void write_reg(logic [lis_pkg::CFG_IDX_W-1:0] idx,
                                logic [lis_pkg::CFG_DAT_W-1:0] data);
            case (idx)
                lis_pkg::CFG_LIGHT_START:    light_start  = data[lis_pkg::HOUR_W-1:0];
                lis_pkg::CFG_LIGHT_LENGTH:   light_length = data[lis_pkg::HOUR_W-1:0];
                lis_pkg::CFG_WATER_INTERVAL: interval_min = data[lis_pkg::WMIN_W-1:0];
                lis_pkg::CFG_WATER_DURATION: duration_min = data[lis_pkg::WMIN_W-1:0];
                lis_pkg::CFG_PH_LOW:         ph_low       = data[lis_pkg::PH_W-1:0];
                lis_pkg::CFG_PH_HIGH:        ph_high      = data[lis_pkg::PH_W-1:0];
                default:                     ;
            endcase
        endfunction

        function int pending();
            return outcomes.size();
        endfunction

        // One schedule tick: refusal checks, light window, watering, pH.
        function lis_pkg::result_t schedule_tick(lis_pkg::tick_t t);
            lis_pkg::result_t r;
            int      hr;
            int      mn;
            int      start_h;
            int      end_h;
            int      target;
            int      mins;
            bit      want;
            bit      pump;
            bit      started;
            bit      stopped;
            longint  now_l;
            longint  last_l;
            longint  since_l;
            longint  interval_s;
            longint  duration_s;
            longint  wait_s;
            r = '0;
            if (!t.cycle_active)
                r.step_status = lis_pkg::STATUS_NO_CYCLE;
            else if (t.now_seconds < lis_pkg::SYNC_THRESHOLD)
                r.step_status = lis_pkg::STATUS_UNSYNCED;
            else if (!t.stage_available)
                r.step_status = lis_pkg::STATUS_NO_STAGE;
            if (r.step_status != lis_pkg::STATUS_RAN)
            begin
                r.lights_wanted = t.lights_now;
                r.pump_command  = t.pump_now;
                refused++;
                return r;
            end

            // Light window [start, (start+length) mod 24), whole day when equal
            hr      = int'(t.local_hour);
            mn      = int'(t.local_minute);
            start_h = int'(light_start);
            end_h   = (int'(light_start) + int'(light_length)) % 24;
            if (start_h < end_h)
                want = (hr >= start_h) && (hr < end_h);
            else
                want = (hr >= start_h) || (hr < end_h);
            target = want ? end_h : start_h;
            if (hr < target)
                mins = (target - hr) * 60 - mn;
            else
                mins = (target + 24 - hr) * 60 - mn;
            if (mins < 0)
                mins = 0;
            if (mins > 1440)
                mins = 1440;

            // Watering; elapsed times are signed so a clock step back never fires
            now_l      = longint'(t.now_seconds);
            last_l     = longint'(last_start);
            interval_s = longint'(interval_min);
            interval_s = interval_s * 60;
            duration_s = longint'(duration_min);
            duration_s = duration_s * 60;
            wait_s     = 0;
            if (last_start != 0)
            begin
                since_l = now_l - last_l;
                wait_s  = interval_s - since_l;
                if (wait_s < 0)
                    wait_s = 0;
                if (wait_s > interval_s)
                    wait_s = interval_s;
            end
            pump    = t.pump_now;
            started = 1'b0;
            stopped = 1'b0;
            if (first_pending)
            begin
                pump          = 1'b1;
                last_start    = t.now_seconds;
                first_pending = 1'b0;
                started       = 1'b1;
            end
            else if (last_start != 0 && (now_l - last_l) >= interval_s)
            begin
                pump       = 1'b1;
                last_start = t.now_seconds;
                started    = 1'b1;
            end
            if (pump)
            begin
                last_l = longint'(pump_since);
                if (pump_since == 0)
                    pump_since = t.now_seconds;
                else if ((now_l - last_l) >= duration_s)
                begin
                    pump       = 1'b0;
                    pump_since = '0;
                    stopped    = 1'b1;
                end
            end
            else
                pump_since = '0;
            if (started)
                starts++;
            if (stopped)
                stops++;

            r.lights_wanted           = want;
            r.lights_toggle           = (want != t.lights_now);
            r.minutes_to_light_change = mins[lis_pkg::MINS_W-1:0];
            r.pump_command            = pump;
            r.pump_started            = started;
            r.pump_stopped            = stopped;
            r.seconds_to_watering     = wait_s[lis_pkg::SECS_W-1:0];
            r.ph_alert                = lis_pkg::ALERT_NONE;
            if (t.ph_present)
            begin
                if (t.ph_sample < ph_low)
                    r.ph_alert = lis_pkg::ALERT_LOW;
                else if (t.ph_sample > ph_high)
                    r.ph_alert = lis_pkg::ALERT_HIGH;
            end
            return r;
        endfunction

        function void note_tick(lis_pkg::tick_t t);
            outcomes.push_back(schedule_tick(t));
        endfunction

        task flag_mismatch(string msg);
            errors++;
            if (errors <= 60)
                $display("[%0t] mismatch: %s", $time, msg);
        endtask

        task compare_field(string fname, longint unsigned got, longint unsigned want_v);
            if (got != want_v)
                flag_mismatch($sformatf("result %0d: %s = %0d, expected %0d",
                                        checked, fname, got, want_v));
        endtask

        task check_outcome(lis_pkg::result_t got);
            lis_pkg::result_t want_r;
            if (outcomes.size() == 0)
            begin
                flag_mismatch("result item arrived with no tick waiting for it");
                return;
            end
            want_r = outcomes.pop_front();
            compare_field("step_status", 64'(got.step_status), 64'(want_r.step_status));
            compare_field("lights_wanted", 64'(got.lights_wanted),
                          64'(want_r.lights_wanted));
            compare_field("lights_toggle", 64'(got.lights_toggle),
                          64'(want_r.lights_toggle));
            compare_field("minutes_to_light_change", 64'(got.minutes_to_light_change),
                          64'(want_r.minutes_to_light_change));
            compare_field("pump_command", 64'(got.pump_command), 64'(want_r.pump_command));
            compare_field("pump_started", 64'(got.pump_started), 64'(want_r.pump_started));
            compare_field("pump_stopped", 64'(got.pump_stopped), 64'(want_r.pump_stopped));
            compare_field("seconds_to_watering", 64'(got.seconds_to_watering),
                          64'(want_r.seconds_to_watering));
            compare_field("ph_alert", 64'(got.ph_alert), 64'(want_r.ph_alert));
            checked++;
        endtask
    endclass

    // ------------------------------------------------------------------
    // Block hookup
    // ------------------------------------------------------------------
    logic                          clk;
    logic                          rst_n;
    logic                          tick_valid;
    logic                          tick_ready;
    lis_pkg::tick_t                tick;
    logic                          result_valid;
    logic                          result_ready;
    lis_pkg::result_t              result;
    logic                          wr_en;
    logic [lis_pkg::CFG_IDX_W-1:0] wr_index;
    logic [lis_pkg::CFG_DAT_W-1:0] wr_data;

    light_and_irrigation_scheduler u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .tick_valid   (tick_valid),
        .tick_ready   (tick_ready),
        .tick         (tick),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .wr_en        (wr_en),
        .wr_index     (wr_index),
        .wr_data      (wr_data)
    );

    tick_ledger ledger;
    int         burst_left;
    bit         hold_req;
    int         holds_done;
    int         settings_applied;
    longint     cursor;          // running epoch time of the generated schedule
    bit         pump_hint;       // pump relay level, held in runs
    longint     cycle_count;

    // ------------------------------------------------------------------
    // Clock, watchdog
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // End the run with a fail once the cycle count passes the limit.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("light_and_irrigation_scheduler regression: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: sample both handshakes at the edge that completes them.
    // Inputs change by nonblocking assignment, so values read here are the
    // ones the block saw at this edge.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (tick_valid && tick_ready)
                ledger.note_tick(tick);
            if (result_valid && result_ready)
                ledger.check_outcome(result);
        end
    end

    // ------------------------------------------------------------------
    // Receiver: stall on a pattern of its own that changes at random,
    // and hold off for a long stretch once when asked.
    // ------------------------------------------------------------------
    initial
    begin : receiver
        int ready_mode;
        int mode_left;
        int beat;
        bit rdy;
        ready_mode = 0;
        mode_left  = 0;
        beat       = 0;
        result_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                // hold off while the sender keeps offering, so the block fills up
                hold_req = 1'b0;
                result_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                holds_done++;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    ready_mode = $urandom_range(0, 3);
                    mode_left  = $urandom_range(16, 96);
                end
                mode_left--;
                beat++;
                case (ready_mode)
                    0:       rdy = 1'b1;
                    1:       rdy = ($urandom_range(0, 9) < 7);
                    2:       rdy = ($urandom_range(0, 9) < 3);
                    default: rdy = (beat % 3 == 0);
                endcase
                result_ready <= rdy;
            end
        end
    end

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------

    // Offer one item and hold it until accepted. Bursts of random length are
    // separated by random gaps; some bursts follow with no gap at all.
    task automatic send_tick(input lis_pkg::tick_t t);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                tick_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        tick       <= t;
        tick_valid <= 1'b1;
        @(posedge clk);
        while (!tick_ready)
            @(posedge clk);
    endtask

    // Drop valid, then wait until every expected result has arrived and the
    // pipeline has had time to empty.
    task automatic settle();
        tick_valid <= 1'b0;
        @(posedge clk);
        while (ledger.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // One register write; the port has no wait.
    task automatic write_reg(input logic [lis_pkg::CFG_IDX_W-1:0] idx,
                             input logic [lis_pkg::CFG_DAT_W-1:0] data);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= data;
        ledger.write_reg(idx, data);
        @(posedge clk);
        wr_en <= 1'b0;
        @(posedge clk);
    endtask

    task automatic apply_settings(input logic [lis_pkg::CFG_DAT_W-1:0] start_h,
                                  input logic [lis_pkg::CFG_DAT_W-1:0] length_h,
                                  input logic [lis_pkg::CFG_DAT_W-1:0] interval_m,
                                  input logic [lis_pkg::CFG_DAT_W-1:0] duration_m,
                                  input logic [lis_pkg::CFG_DAT_W-1:0] low_ph,
                                  input logic [lis_pkg::CFG_DAT_W-1:0] high_ph);
        write_reg(lis_pkg::CFG_LIGHT_START, start_h);
        write_reg(lis_pkg::CFG_LIGHT_LENGTH, length_h);
        write_reg(lis_pkg::CFG_WATER_INTERVAL, interval_m);
        write_reg(lis_pkg::CFG_WATER_DURATION, duration_m);
        write_reg(lis_pkg::CFG_PH_LOW, low_ph);
        write_reg(lis_pkg::CFG_PH_HIGH, high_ph);
        settings_applied++;
    endtask

    // Occasionally set bits above a narrow register's width; they must be dropped.
    function automatic logic [lis_pkg::CFG_DAT_W-1:0] with_stray_bits(
        input logic [lis_pkg::CFG_DAT_W-1:0] v, input int w);
        logic [lis_pkg::CFG_DAT_W-1:0] mask;
        mask = (16'd1 << w) - 16'd1;
        if ($urandom_range(0, 9) == 0)
            return v | (16'($urandom) & ~mask);
        return v;
    endfunction

    task automatic random_settings();
        logic [lis_pkg::CFG_DAT_W-1:0] s;
        logic [lis_pkg::CFG_DAT_W-1:0] l;
        logic [lis_pkg::CFG_DAT_W-1:0] iv;
        logic [lis_pkg::CFG_DAT_W-1:0] du;
        logic [lis_pkg::CFG_DAT_W-1:0] lo;
        logic [lis_pkg::CFG_DAT_W-1:0] hi;
        logic [lis_pkg::CFG_DAT_W-1:0] swap;
        s = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(24, 31))
                                        : 16'($urandom_range(0, 23));
        l = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(25, 31))
                                        : 16'($urandom_range(0, 24));
        case ($urandom_range(0, 5))
            0:       iv = 16'd0;
            1:       iv = 16'($urandom_range(1, 3));
            2:       iv = 16'($urandom_range(4, 30));
            3:       iv = 16'd60;
            4:       iv = 16'($urandom_range(0, 1000));
            default: iv = 16'hFFFF;
        endcase
        case ($urandom_range(0, 4))
            0:       du = 16'd0;
            1:       du = 16'($urandom_range(1, 3));
            2:       du = 16'($urandom_range(0, iv));
            3:       du = 16'hFFFF;
            default: du = iv;
        endcase
        lo = 16'($urandom_range(0, 1400));
        hi = 16'($urandom_range(0, 1400));
        // keep most ranges ordered, leave some crossed
        if (lo > hi && $urandom_range(0, 9) < 7)
        begin
            swap = lo;
            lo   = hi;
            hi   = swap;
        end
        if ($urandom_range(0, 19) == 0)
            hi = 16'd2047;
        apply_settings(with_stray_bits(s, lis_pkg::HOUR_W), with_stray_bits(l, lis_pkg::HOUR_W),
                       iv, du,
                       with_stray_bits(lo, lis_pkg::PH_W), with_stray_bits(hi, lis_pkg::PH_W));
    endtask

    function automatic lis_pkg::tick_t make_tick(input logic [lis_pkg::NOW_W-1:0] now_s,
                                                 input int hr, input int mn,
                                                 input int active, input int stage,
                                                 input int lights, input int pump,
                                                 input int ph, input int ph_ok);
        lis_pkg::tick_t t;
        t.now_seconds     = now_s;
        t.local_hour      = hr[lis_pkg::HOUR_W-1:0];
        t.local_minute    = mn[lis_pkg::MINUTE_W-1:0];
        t.cycle_active    = active[0];
        t.stage_available = stage[0];
        t.lights_now      = lights[0];
        t.pump_now        = pump[0];
        t.ph_sample       = ph[lis_pkg::PH_W-1:0];
        t.ph_present      = ph_ok[0];
        return t;
    endfunction

    // Mostly well-formed ticks: time moves forward in short steps or in steps
    // scaled to the watering interval, hour and minute follow the time. The rest are
    // refusals, steps backward, jumps and out-of-range clock fields.
    function automatic lis_pkg::tick_t random_tick();
        lis_pkg::tick_t t;
        int     kind;
        int     pick;
        longint step;
        longint span;
        t    = '0;
        kind = $urandom_range(0, 99);
        pick = $urandom_range(0, 99);
        span = longint'(ledger.interval_min);
        span = span * 20 + 60;
        if (pick < 60)
            step = longint'($urandom_range(0, 90));
        else if (pick < 85)
            step = longint'($urandom_range(0, 32'(span)));
        else if (pick < 95)
            step = longint'($urandom_range(0, 32'(3 * span)));
        else
        begin
            step = longint'($urandom_range(1, 900));
            step = -step;
        end
        cursor = cursor + step;
        if (cursor < SYNC_SECONDS || cursor > 64'hFFFF_FFFF || $urandom_range(0, 99) == 0)
        begin
            if ($urandom_range(0, 4) == 0)
                cursor = 64'hFFFF_FFFF - longint'($urandom_range(0, 5000));
            else
                cursor = SYNC_SECONDS + longint'($urandom_range(0, 32'd3000000000));
        end
        t.now_seconds = cursor[lis_pkg::NOW_W-1:0];
        if ($urandom_range(0, 9) == 0)
        begin
            t.local_hour   = lis_pkg::HOUR_W'($urandom_range(0, 31));
            t.local_minute = lis_pkg::MINUTE_W'($urandom_range(0, 63));
        end
        else
        begin
            t.local_hour   = lis_pkg::HOUR_W'((cursor / 3600) % 24);
            t.local_minute = lis_pkg::MINUTE_W'((cursor / 60) % 60);
        end
        t.cycle_active    = 1'b1;
        t.stage_available = 1'b1;
        if (kind < 6)
            t.cycle_active = 1'b0;
        else if (kind < 10)
            t.now_seconds = $urandom_range(0, 999999999);
        else if (kind < 14)
            t.stage_available = 1'b0;
        t.lights_now = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 4) == 0)
            pump_hint = ~pump_hint;
        t.pump_now = pump_hint;
        case ($urandom_range(0, 3))
            0:       t.ph_sample = ledger.ph_low - 11'd1
                                   + lis_pkg::PH_W'($urandom_range(0, 2));
            1:       t.ph_sample = ledger.ph_high - 11'd1
                                   + lis_pkg::PH_W'($urandom_range(0, 2));
            2:       t.ph_sample = lis_pkg::PH_W'($urandom_range(0, 1400));
            default: t.ph_sample = lis_pkg::PH_W'($urandom_range(0, 2047));
        endcase
        t.ph_present = ($urandom_range(0, 6) != 0);
        return t;
    endfunction

    task automatic random_phase(input int n, input bit with_hold);
        if (with_hold)
            hold_req = 1'b1;
        repeat (n) send_tick(random_tick());
        settle();
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        ledger           = new();
        burst_left       = 0;
        hold_req         = 1'b0;
        holds_done       = 0;
        settings_applied = 0;
        pump_hint        = 1'b0;
        cycle_count      = 0;
        cursor           = SYNC_SECONDS + 64'd5000;
        tick_valid <= 1'b0;
        tick       <= '0;
        wr_en      <= 1'b0;
        wr_index   <= '0;
        wr_data    <= '0;
        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed, reset settings: refusals in priority order, first tick,
        // pH extremes and limits, duration stop, restart, clock step back,
        // out-of-range hour and minute, top of the time range.
        send_tick(make_tick(32'hFFFF_FFFF, 31, 63, 0, 1, 1, 1, 2047, 1));
        send_tick(make_tick(32'd999999999, 5, 5, 1, 1, 0, 1, 600, 1));
        send_tick(make_tick(32'd0, 0, 0, 0, 0, 1, 0, 0, 0));
        send_tick(make_tick(32'd1000000000, 12, 0, 1, 0, 1, 1, 600, 1));
        send_tick(make_tick(32'd1000000000, 0, 0, 1, 1, 0, 0, 0, 1));
        send_tick(make_tick(32'd1000000060, 23, 59, 1, 1, 1, 1, 1400, 1));
        send_tick(make_tick(32'd1000000300, 6, 0, 1, 1, 0, 1, 550, 1));
        send_tick(make_tick(32'd1000000301, 17, 59, 1, 1, 1, 0, 650, 1));
        send_tick(make_tick(32'd1000003600, 18, 0, 1, 1, 1, 0, 651, 1));
        send_tick(make_tick(32'd1000003500, 5, 59, 1, 1, 0, 1, 549, 1));
        send_tick(make_tick(32'd1000003700, 31, 63, 1, 1, 1, 1, 2047, 0));
        send_tick(make_tick(32'hFFFF_FFFF, 24, 60, 1, 1, 0, 1, 1399, 1));
        settle();

        // Whole-day light window, watering on every tick, zero duration.
        write_reg(lis_pkg::CFG_LIGHT_LENGTH, 16'd0);
        write_reg(lis_pkg::CFG_WATER_INTERVAL, 16'd0);
        write_reg(lis_pkg::CFG_WATER_DURATION, 16'd0);
        send_tick(make_tick(32'd2000000000, 3, 10, 1, 1, 0, 0, 600, 1));
        send_tick(make_tick(32'd2000000001, 12, 30, 1, 1, 1, 1, 600, 1));
        send_tick(make_tick(32'd2000000001, 23, 59, 1, 1, 1, 1, 600, 1));
        settle();

        // Window wrapping past midnight, restart and stop on one tick,
        // crossed pH limits; unmapped indexes must change nothing.
        apply_settings(16'd20, 16'd10, 16'd10, 16'd10, 16'd700, 16'd600);
        write_reg(CFG_SPARE_6, 16'hFFFF);
        write_reg(CFG_SPARE_7, 16'h0000);
        send_tick(make_tick(32'd3000000000, 21, 0, 1, 1, 0, 1, 650, 1));
        send_tick(make_tick(32'd3000000001, 22, 0, 1, 1, 1, 1, 650, 1));
        send_tick(make_tick(32'd3000000601, 2, 30, 1, 1, 1, 1, 500, 1));
        send_tick(make_tick(32'd3000000700, 4, 0, 1, 1, 0, 0, 800, 1));
        settle();

        // Random part: extremes of every register first, then random settings.
        apply_settings(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        random_phase(PHASE_ITEMS, 1'b0);
        apply_settings(16'd23, 16'd24, 16'hFFFF, 16'hFFFF, 16'd1400, 16'd1400);
        random_phase(PHASE_ITEMS, 1'b0);
        apply_settings(16'd31, 16'd31, 16'd1, 16'd1, 16'd2047, 16'd2047);
        random_phase(PHASE_ITEMS, 1'b0);
        for (int i = 0; i < RANDOM_SETS - 3; i++)
        begin
            random_settings();
            random_phase(PHASE_ITEMS, i == 1);
        end

        if (ledger.pending() != 0)
            ledger.flag_mismatch($sformatf("%0d expected results never arrived",
                                           ledger.pending()));
        $display("covered %0d ticks (%0d refused) over %0d register settings",
                 ledger.checked, ledger.refused, settings_applied);
        $display("watering starts %0d, duration stops %0d, long receiver hold-offs %0d",
                 ledger.starts, ledger.stops, holds_done);
        if (ledger.errors == 0)
            $display("light_and_irrigation_scheduler regression: pass");
        else
            $display("light_and_irrigation_scheduler regression: fail");
        $finish;
    end

endmodule
